>>> sv/bti_pkg.sv
// shared types and constants for the bilinear table interpolator
`timescale 1ns / 1ps
package bti_pkg;

  // table size defaults
  localparam int MAX_X_POINTS_DEF = 64;
  localparam int MAX_Y_POINTS_DEF = 64;

  // field and register widths
  localparam int KIND_W  = 2;
  localparam int INDEX_W = 12;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;
  localparam int CFG_IDX_W = 1;
  localparam int PROD_W = 2 * VALUE_W;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_WR_X   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WR_Y   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WR_GRID = 2'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_X_POINTS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_POINTS = 1'd1;

  // input beat
  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [INDEX_W-1:0]        entry_index;
    logic signed [VALUE_W-1:0] entry_value;
    logic signed [VALUE_W-1:0] query_x;
    logic signed [VALUE_W-1:0] query_y;
  } req_t;

  // output beat
  typedef struct packed {
    logic signed [VALUE_W-1:0] result_value;
    logic                      in_range;
  } rsp_t;

  // operands of one linear step
  typedef struct packed {
    logic signed [VALUE_W-1:0] p1;
    logic signed [VALUE_W-1:0] p2;
    logic signed [VALUE_W-1:0] z1;
    logic signed [VALUE_W-1:0] z2;
    logic signed [VALUE_W-1:0] q;
  } lin_req_t;

endpackage

>>> sv/bti_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module bti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/bti_lin.sv
// linear step unit: z1 + (q - p1) * (z2 - z1) / (p2 - p1), one quotient bit per cycle
`timescale 1ns / 1ps
module bti_lin (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  bti_pkg::lin_req_t                 req,
  output logic                              done,
  output logic signed [bti_pkg::VALUE_W-1:0] res
);

  localparam int VW = bti_pkg::VALUE_W;
  localparam int PW = bti_pkg::PROD_W;
  localparam int CW = $clog2(PW);

  typedef enum logic [2:0] {L_IDLE, L_MUL, L_DIV, L_FIN} lstate_t;

  lstate_t               state;
  logic [VW-1:0]         mp;
  logic [VW-1:0]         mq;
  logic [VW-1:0]         mz;
  logic                  neg;
  logic [PW-1:0]         prod;
  logic [VW-1:0]         rem;
  logic [VW-1:0]         quo;
  logic [CW-1:0]         cnt;
  logic signed [VW-1:0]  z1;

  logic signed [VW:0] dp;
  logic signed [VW:0] dq;
  logic signed [VW:0] dz;
  logic signed [VW:0] dqc;
  logic [VW:0]        trial;
  logic               qbit;
  logic [VW+1:0]      sum;

  function automatic logic [VW-1:0] mag(input logic signed [VW:0] v);
    logic signed [VW:0] n;
    n = -v;
    return v[VW] ? n[VW-1:0] : v[VW-1:0];
  endfunction

  // differences and offset clamp
  always_comb begin
    dp = {req.p2[VW-1], req.p2} - {req.p1[VW-1], req.p1};
    dq = {req.q[VW-1], req.q} - {req.p1[VW-1], req.p1};
    dz = {req.z2[VW-1], req.z2} - {req.z1[VW-1], req.z1};
    if (!dp[VW]) begin
      if (dq[VW]) dqc = '0;
      else if (dq > dp) dqc = dp;
      else dqc = dq;
    end else begin
      if (!dq[VW]) dqc = '0;
      else if (dq < dp) dqc = dp;
      else dqc = dq;
    end
  end

  // restoring divide step
  always_comb begin
    trial = {rem, prod[PW-1]};
    qbit  = trial >= {1'b0, mp};
  end

  // final add or subtract
  always_comb begin
    if (neg) sum = {z1[VW-1], z1[VW-1], z1} - {2'b00, quo};
    else sum = {z1[VW-1], z1[VW-1], z1} + {2'b00, quo};
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == L_FIN);
      case (state)
        L_IDLE: begin
          if (start) begin
            mp  <= mag(dp);
            mq  <= mag(dqc);
            mz  <= mag(dz);
            neg <= (dqc[VW] ^ dz[VW]) ^ dp[VW];
            z1  <= req.z1;
            quo <= '0;
            if (req.p1 == req.p2) state <= L_FIN;
            else state <= L_MUL;
          end
        end
        L_MUL: begin
          prod  <= mq * mz;
          rem   <= '0;
          cnt   <= '0;
          state <= L_DIV;
        end
        L_DIV: begin
          if (qbit) rem <= VW'(trial - {1'b0, mp});
          else rem <= trial[VW-1:0];
          prod <= {prod[PW-2:0], 1'b0};
          quo  <= {quo[VW-2:0], qbit};
          cnt  <= cnt + CW'(1);
          if (cnt == CW'(PW - 1)) state <= L_FIN;
        end
        L_FIN: begin
          res   <= sum[VW-1:0];
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

>>> sv/bilinear_table_interpolator.sv
// top level: table storage, bracket search and interpolation sequencer
// write beats are taken while idle; a query runs an axis scan over the point counts in use,
// a fetch and a hand-off, then up to three linear steps (a step skips the divide when its
// bracket points are equal) in the shared bit-serial divide unit
// one query is worked on at a time; a finished result waits in the output register
// while the next beat is taken
// reset clears control state and sets x_points and y_points to 2; tables hold garbage
`timescale 1ns / 1ps
module bilinear_table_interpolator #(
  parameter int MAX_X_POINTS = bti_pkg::MAX_X_POINTS_DEF,
  parameter int MAX_Y_POINTS = bti_pkg::MAX_Y_POINTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  bti_pkg::req_t                    req,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output bti_pkg::rsp_t                    rsp,
  input  logic                             cfg_we,
  input  logic [bti_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bti_pkg::COUNT_W-1:0]      cfg_data
);

  localparam int VW  = bti_pkg::VALUE_W;
  localparam int XW  = $clog2(MAX_X_POINTS);
  localparam int YW  = $clog2(MAX_Y_POINTS);
  localparam int GD  = MAX_X_POINTS * MAX_Y_POINTS;
  localparam int GW  = $clog2(GD);
  localparam int NXW = $clog2(MAX_X_POINTS + 1);
  localparam int NYW = $clog2(MAX_Y_POINTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_BRK, S_ROW, S_FETCH, S_DEC, S_LSTART, S_LWAIT, S_DONE
  } state_t;

  typedef enum logic [1:0] {P_ROW1, P_ROW2, P_COL} phase_t;

  state_t state;
  phase_t phase;

  logic [bti_pkg::COUNT_W-1:0] x_points;
  logic [bti_pkg::COUNT_W-1:0] y_points;

  logic signed [VW-1:0] qx;
  logic signed [VW-1:0] qy;
  logic [NXW-1:0] nx;
  logic [NXW-1:0] nx_next;
  logic [NYW-1:0] ny_next;
  logic [XW-1:0]  xlast;
  logic [YW-1:0]  ylast;

  // scan state
  logic [XW-1:0] xk;
  logic [XW-1:0] xkd;
  logic [XW-1:0] xc;
  logic          xrun;
  logic          xv;
  logic          xlow;
  logic          xhigh;
  logic [YW-1:0] yk;
  logic [YW-1:0] ykd;
  logic [YW-1:0] yc;
  logic          yrun;
  logic          yv;
  logic          ylow;
  logic          yhigh;

  // brackets and fetched values
  logic [XW-1:0] i1;
  logic [XW-1:0] i2;
  logic [YW-1:0] j1;
  logic [YW-1:0] j2;
  logic [GW-1:0] row1;
  logic [GW-1:0] row2;
  logic [2:0]    fs;
  logic          inr;
  logic          hity;
  logic signed [VW-1:0] xa1;
  logic signed [VW-1:0] xa2;
  logic signed [VW-1:0] ya1;
  logic signed [VW-1:0] ya2;
  logic signed [VW-1:0] z11;
  logic signed [VW-1:0] z21;
  logic signed [VW-1:0] z12;
  logic signed [VW-1:0] z22;
  logic signed [VW-1:0] a;
  logic signed [VW-1:0] b;
  logic signed [VW-1:0] res;

  // memory ports
  logic                 accept;
  logic                 x_we;
  logic                 y_we;
  logic                 g_we;
  logic [XW-1:0]        x_raddr;
  logic [YW-1:0]        y_raddr;
  logic [GW-1:0]        g_raddr;
  logic signed [VW-1:0] xrd;
  logic signed [VW-1:0] yrd;
  logic signed [VW-1:0] grd;

  // linear unit
  logic                 lin_start;
  logic                 lin_done;
  bti_pkg::lin_req_t    lin_req;
  logic signed [VW-1:0] lin_res;

  // point counts in use, clamped to 2 .. max
  always_comb begin
    if (x_points < bti_pkg::COUNT_W'(2)) nx_next = NXW'(2);
    else if (32'(x_points) > MAX_X_POINTS) nx_next = NXW'(MAX_X_POINTS);
    else nx_next = NXW'(x_points);
    if (y_points < bti_pkg::COUNT_W'(2)) ny_next = NYW'(2);
    else if (32'(y_points) > MAX_Y_POINTS) ny_next = NYW'(MAX_Y_POINTS);
    else ny_next = NYW'(y_points);
  end

  // input handshake and table writes
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign x_we = accept && (req.kind == bti_pkg::KIND_WR_X)
                && (32'(req.entry_index) < MAX_X_POINTS);
  assign y_we = accept && (req.kind == bti_pkg::KIND_WR_Y)
                && (32'(req.entry_index) < MAX_Y_POINTS);
  assign g_we = accept && (req.kind == bti_pkg::KIND_WR_GRID)
                && (32'(req.entry_index) < GD);

  // read address selection
  always_comb begin
    if (state == S_SCAN) begin
      x_raddr = xk;
      y_raddr = yk;
    end else if (fs == 3'd0) begin
      x_raddr = i1;
      y_raddr = j1;
    end else begin
      x_raddr = i2;
      y_raddr = j2;
    end
    case (fs)
      3'd0:    g_raddr = GW'(i1) + row1;
      3'd1:    g_raddr = GW'(i2) + row1;
      3'd2:    g_raddr = GW'(i1) + row2;
      default: g_raddr = GW'(i2) + row2;
    endcase
  end

  // operands of the current linear step
  always_comb begin
    case (phase)
      P_ROW1:  lin_req = '{p1: xa1, p2: xa2, z1: z11, z2: z21, q: qx};
      P_ROW2:  lin_req = '{p1: xa1, p2: xa2, z1: z12, z2: z22, q: qx};
      default: lin_req = '{p1: ya1, p2: ya2, z1: a, z2: b, q: qy};
    endcase
  end

  assign lin_start = (state == S_LSTART);

  bti_ram #(.WIDTH(VW), .DEPTH(MAX_X_POINTS)) u_x_axis (
    .clk(clk), .we(x_we), .waddr(XW'(req.entry_index)), .wdata(req.entry_value),
    .raddr(x_raddr), .rdata(xrd)
  );

  bti_ram #(.WIDTH(VW), .DEPTH(MAX_Y_POINTS)) u_y_axis (
    .clk(clk), .we(y_we), .waddr(YW'(req.entry_index)), .wdata(req.entry_value),
    .raddr(y_raddr), .rdata(yrd)
  );

  bti_ram #(.WIDTH(VW), .DEPTH(GD)) u_grid (
    .clk(clk), .we(g_we), .waddr(GW'(req.entry_index)), .wdata(req.entry_value),
    .raddr(g_raddr), .rdata(grd)
  );

  bti_lin u_lin (
    .clk(clk), .rst(rst), .start(lin_start), .req(lin_req),
    .done(lin_done), .res(lin_res)
  );

  // sequencer, config registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= P_ROW1;
      x_points  <= bti_pkg::COUNT_W'(2);
      y_points  <= bti_pkg::COUNT_W'(2);
      rsp_valid <= 1'b0;
      xrun      <= 1'b0;
      yrun      <= 1'b0;
      xv        <= 1'b0;
      yv        <= 1'b0;
      fs        <= 3'd0;
    end else begin
      // config writes
      if (cfg_we) begin
        if (cfg_index == bti_pkg::REG_X_POINTS) x_points <= cfg_data;
        if (cfg_index == bti_pkg::REG_Y_POINTS) y_points <= cfg_data;
      end
      // output beat taken with nothing new to load
      if (rsp_valid && !rsp_stall && state != S_DONE) rsp_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (accept && req.kind == bti_pkg::KIND_QUERY) begin
            qx    <= req.query_x;
            qy    <= req.query_y;
            nx    <= nx_next;
            xlast <= XW'(nx_next - NXW'(1));
            ylast <= YW'(ny_next - NYW'(1));
            xk    <= '0;
            yk    <= '0;
            xc    <= '0;
            yc    <= '0;
            xrun  <= 1'b1;
            yrun  <= 1'b1;
            xv    <= 1'b0;
            yv    <= 1'b0;
            xlow  <= 1'b0;
            xhigh <= 1'b0;
            ylow  <= 1'b0;
            yhigh <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // x axis: one point read per cycle, compared in the next cycle against the read data
          if (xrun) begin
            xk   <= xk + XW'(1);
            xrun <= (xk != xlast);
          end
          xv  <= xrun;
          xkd <= xk;
          if (xv) begin
            if (xkd == '0 && qx < xrd) xlow <= 1'b1;
            if (xkd == xlast && qx > xrd) xhigh <= 1'b1;
            if (xkd != '0 && xkd != xlast && xrd <= qx) xc <= xc + XW'(1);
          end
          // y axis in parallel
          if (yrun) begin
            yk   <= yk + YW'(1);
            yrun <= (yk != ylast);
          end
          yv  <= yrun;
          ykd <= yk;
          if (yv) begin
            if (ykd == '0 && qy < yrd) ylow <= 1'b1;
            if (ykd == ylast && qy > yrd) yhigh <= 1'b1;
            if (ykd != '0 && ykd != ylast && yrd <= qy) yc <= yc + YW'(1);
          end
          if (!xrun && !xv && !yrun && !yv) state <= S_BRK;
        end
        S_BRK: begin
          // low test wins over high test
          if (xlow) begin
            i1 <= '0;
            i2 <= '0;
          end else if (xhigh) begin
            i1 <= xlast;
            i2 <= xlast;
          end else begin
            i1 <= xc;
            i2 <= xc + XW'(1);
          end
          if (ylow) begin
            j1 <= '0;
            j2 <= '0;
          end else if (yhigh) begin
            j1 <= ylast;
            j2 <= ylast;
          end else begin
            j1 <= yc;
            j2 <= yc + YW'(1);
          end
          inr   <= !(xlow || xhigh || ylow || yhigh);
          state <= S_ROW;
        end
        S_ROW: begin
          row1  <= GW'(j1) * GW'(nx);
          row2  <= GW'(j2) * GW'(nx);
          fs    <= 3'd0;
          state <= S_FETCH;
        end
        S_FETCH: begin
          // addresses go out on fs, data lands in the next cycle
          fs <= fs + 3'd1;
          case (fs)
            3'd1: begin
              xa1 <= xrd;
              ya1 <= yrd;
              z11 <= grd;
            end
            3'd2: begin
              xa2 <= xrd;
              ya2 <= yrd;
              z21 <= grd;
            end
            3'd3: z12 <= grd;
            3'd4: begin
              z22   <= grd;
              state <= S_DEC;
            end
            default: ;
          endcase
        end
        S_DEC: begin
          fs   <= 3'd0;
          hity <= (qy == ya1);
          if (qx == xa1 && qy == ya1) begin
            res   <= z11;
            state <= S_DONE;
          end else if (qx == xa1) begin
            a     <= z11;
            b     <= z12;
            phase <= P_COL;
            state <= S_LSTART;
          end else begin
            phase <= P_ROW1;
            state <= S_LSTART;
          end
        end
        S_LSTART: state <= S_LWAIT;
        S_LWAIT: begin
          if (lin_done) begin
            case (phase)
              P_ROW1: begin
                a <= lin_res;
                if (hity) begin
                  res   <= lin_res;
                  state <= S_DONE;
                end else begin
                  phase <= P_ROW2;
                  state <= S_LSTART;
                end
              end
              P_ROW2: begin
                b     <= lin_res;
                phase <= P_COL;
                state <= S_LSTART;
              end
              default: begin
                res   <= lin_res;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid        <= 1'b1;
            rsp.result_value <= res;
            rsp.in_range     <= inr;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
